// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the patch point query block.
// No dependencies; define SYNTH to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked only while reset is released.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// File: sv/lpq_pkg.sv
// Types, constants and helper functions for the lat/lon patch point query block.
// No dependencies; used by every module of the block.
package lpq_pkg;

    localparam int ANGLE_BITS     = 24;
    localparam int WIDE_BITS      = ANGLE_BITS + 2;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = ANGLE_BITS;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic        [ANGLE_BITS-2:0] half_t;
    typedef logic        [ANGLE_BITS-1:0] mag_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic        [CFG_DATA_BITS-1:0]  cfg_data_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t REG_CENTER_LAT = cfg_index_t'(0);
    localparam cfg_index_t REG_CENTER_LON = cfg_index_t'(1);
    localparam cfg_index_t REG_HALF_LAT   = cfg_index_t'(2);
    localparam cfg_index_t REG_HALF_LON   = cfg_index_t'(3);

    // Binary-angle constants: a full turn is 2^ANGLE_BITS.
    localparam mag_t  HALF_TURN    = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam wide_t QUARTER_TURN = wide_t'(2 ** (ANGLE_BITS - 2));

    typedef struct packed {
        angle_t center_lat;
        angle_t center_lon;
        half_t  half_lat;
        half_t  half_lon;
    } cfg_t;

    typedef struct packed {
        logic   in_range;  // plain difference within the half size
        angle_t clamp;     // wrapped point clamped to the box, wrapped
        angle_t corner;    // nearest edge by sign of the wrapped difference
        mag_t   dist_mag;  // magnitude of the wrapped difference
    } axis_res_t;

    function automatic wide_t clamp_wide(wide_t x, wide_t lo, wide_t hi);
        wide_t r;
        r = x;
        if (r < lo) begin
            r = lo;
        end
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// File: sv/latlon_patch_point_query_unit.sv
// Throughput: one item per cycle, unless the result side stalls with both stages full.
// Each item is registered on entry, evaluated by one pass of add/compare/clamp logic,
// and captured in the result register. The configuration registers and both valid
// flags are cleared by a synchronous active-low reset; the patch is then a single point
// at latitude and longitude zero.
// Depends on lpq_pkg, lpq_cfg_regs, lpq_axis, lpq_reflect and assert_macros.svh.
`include "assert_macros.svh"

module latlon_patch_point_query_unit (
    input  logic                       aclk,
    input  logic                       aresetn,

    // Configuration write port. Writes are expected only while the block is idle.
    input  logic                       cfg_wr_en,
    input  lpq_pkg::cfg_index_t        cfg_index,
    input  lpq_pkg::cfg_data_t         cfg_wdata,

    // Query items.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [23:0] point_lat, [47:24] point_lon
    input  logic [47:0]                s_axis_tdata,

    // Result items.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] inside_res, [24:1] clamp_lat, [48:25] clamp_lon, [72:49] corner_lat,
    // [96:73] corner_lon, [120:97] near_lat, [144:121] near_lon, [151:145] zero
    output logic [151:0]               m_axis_tdata
);

    lpq_pkg::cfg_t cfg;

    lpq_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wdata   (cfg_wdata),
        .cfg     (cfg)
    );

    // Input stage. It frees up whenever the result register can take its item,
    // so a new item is taken every cycle unless the result side stalls with
    // both stages full.
    logic            s1_valid_reg, s1_valid_next;
    lpq_pkg::angle_t s1_lat_reg, s1_lon_reg;
    logic            out_adv;
    logic            in_acc;

    // Result stage.
    logic            m_valid_reg, m_valid_next;
    logic            inside_reg;
    lpq_pkg::angle_t clamp_lat_reg, clamp_lon_reg;
    lpq_pkg::angle_t corner_lat_reg, corner_lon_reg;
    lpq_pkg::angle_t near_lat_reg;

    lpq_pkg::axis_res_t lat_res, lon_res;
    lpq_pkg::angle_t    near_lat;
    logic               in_patch;

    assign out_adv       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_acc) begin
            s1_valid_next = 1'b1;
        end else if (out_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_lat_reg <= lpq_pkg::angle_t'(s_axis_tdata[23:0]);
            s1_lon_reg <= lpq_pkg::angle_t'(s_axis_tdata[47:24]);
        end
    end

    // Per-axis clamp, corner and inside test on the registered point.
    lpq_axis u_lat (
        .point  (s1_lat_reg),
        .center (cfg.center_lat),
        .half   (cfg.half_lat),
        .res    (lat_res)
    );

    lpq_axis u_lon (
        .point  (s1_lon_reg),
        .center (cfg.center_lon),
        .half   (cfg.half_lon),
        .res    (lon_res)
    );

    // Great-circle latitude; the great-circle longitude is the clamped one.
    lpq_reflect u_refl (
        .point_lat  (s1_lat_reg),
        .center_lat (cfg.center_lat),
        .half_lat   (cfg.half_lat),
        .half_lon   (cfg.half_lon),
        .lon_mag    (lon_res.dist_mag),
        .clamp_lat  (lat_res.clamp),
        .near_lat   (near_lat)
    );

    assign in_patch = lat_res.in_range && lon_res.in_range;

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            inside_reg     <= in_patch;
            clamp_lat_reg  <= lat_res.clamp;
            clamp_lon_reg  <= lon_res.clamp;
            corner_lat_reg <= lat_res.corner;
            corner_lon_reg <= lon_res.corner;
            near_lat_reg   <= near_lat;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0000000, clamp_lon_reg, near_lat_reg,
                            corner_lon_reg, corner_lat_reg,
                            clamp_lon_reg, clamp_lat_reg, inside_reg};

    // No result may appear in the cycle after reset is applied.
    `ASSERT_CLK(a_no_result_after_reset, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // An item in the input stage moves into the result register when it has room.
    `ASSERT_CLK_RST(a_stage_moves, aclk, aresetn, s1_valid_reg && out_adv |=> m_axis_tvalid, "input stage item was lost")

    // A point inside the patch clamps to itself.
    `ASSERT_CLK_RST(a_inside_clamp, aclk, aresetn, s1_valid_reg && out_adv && in_patch |=> clamp_lat_reg == $past(s1_lat_reg) && clamp_lon_reg == $past(s1_lon_reg), "inside point was moved by clamp")

endmodule

// File: sv/lpq_cfg_regs.sv
// Configuration registers of the patch point query block: center and half sizes.
// Depends on lpq_pkg.
module lpq_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  lpq_pkg::cfg_index_t index,
    input  lpq_pkg::cfg_data_t  wdata,
    output lpq_pkg::cfg_t       cfg
);

    lpq_pkg::cfg_t cfg_reg;
    lpq_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                lpq_pkg::REG_CENTER_LAT: cfg_next.center_lat = lpq_pkg::angle_t'(wdata);
                lpq_pkg::REG_CENTER_LON: cfg_next.center_lon = lpq_pkg::angle_t'(wdata);
                lpq_pkg::REG_HALF_LAT:
                    cfg_next.half_lat = wdata[lpq_pkg::ANGLE_BITS-2:0];
                lpq_pkg::REG_HALF_LON:
                    cfg_next.half_lon = wdata[lpq_pkg::ANGLE_BITS-2:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/lpq_axis.sv
// One axis of the point query: inside test, clamp and nearest corner.
// Depends on lpq_pkg.
module lpq_axis (
    input  lpq_pkg::angle_t    point,
    input  lpq_pkg::angle_t    center,
    input  lpq_pkg::half_t     half,
    output lpq_pkg::axis_res_t res
);

    lpq_pkg::wide_t p_w, c_w, h_w, diff, abs_diff;
    lpq_pkg::wide_t d_w, n_w, lo_w, hi_w, cl_w, k_w;
    lpq_pkg::angle_t d;

    always_comb begin
        p_w  = lpq_pkg::wide_t'(point);
        c_w  = lpq_pkg::wide_t'(center);
        h_w  = lpq_pkg::wide_t'({2'b00, 1'b0, half});
        diff = p_w - c_w;
        abs_diff = diff[lpq_pkg::WIDE_BITS-1] ? -diff : diff;

        // Wrapped difference keeps the low ANGLE_BITS bits.
        d    = lpq_pkg::angle_t'(diff[lpq_pkg::ANGLE_BITS-1:0]);
        d_w  = lpq_pkg::wide_t'(d);
        n_w  = c_w + d_w;
        lo_w = c_w - h_w;
        hi_w = c_w + h_w;
        cl_w = lpq_pkg::clamp_wide(n_w, lo_w, hi_w);
        // A zero difference picks the low side.
        k_w  = (!d[lpq_pkg::ANGLE_BITS-1] && (d != '0)) ? hi_w : lo_w;

        res.in_range = (abs_diff <= h_w);
        res.clamp    = lpq_pkg::angle_t'(cl_w[lpq_pkg::ANGLE_BITS-1:0]);
        res.corner   = lpq_pkg::angle_t'(k_w[lpq_pkg::ANGLE_BITS-1:0]);
        res.dist_mag = d[lpq_pkg::ANGLE_BITS-1] ? (lpq_pkg::mag_t'(0) - lpq_pkg::mag_t'(d))
                                                : lpq_pkg::mag_t'(d);
    end

endmodule

// File: sv/lpq_reflect.sv
// Great-circle latitude of the query: reflects latitude over the pole when the
// longitude gap beyond the patch edge exceeds a quarter turn. Depends on lpq_pkg.
module lpq_reflect (
    input  lpq_pkg::angle_t point_lat,
    input  lpq_pkg::angle_t center_lat,
    input  lpq_pkg::half_t  half_lat,
    input  lpq_pkg::half_t  half_lon,
    input  lpq_pkg::mag_t   lon_mag,
    input  lpq_pkg::angle_t clamp_lat,
    output lpq_pkg::angle_t near_lat
);

    lpq_pkg::mag_t  d_u, t_u;
    lpq_pkg::wide_t c_w, h_w, r_w, rc_w, gap;

    always_comb begin
        c_w = lpq_pkg::wide_t'(center_lat);
        h_w = lpq_pkg::wide_t'({2'b00, 1'b0, half_lat});
        // Wrapped latitude difference, then half turn minus twice the center
        // minus that difference, all modulo a full turn.
        d_u = lpq_pkg::mag_t'(point_lat) - lpq_pkg::mag_t'(center_lat);
        t_u = lpq_pkg::HALF_TURN - {center_lat[lpq_pkg::ANGLE_BITS-2:0], 1'b0} - d_u;
        r_w = c_w + lpq_pkg::wide_t'(lpq_pkg::angle_t'(t_u));
        rc_w = lpq_pkg::clamp_wide(r_w, c_w - h_w, c_w + h_w);

        gap = lpq_pkg::wide_t'({2'b00, lon_mag}) -
              lpq_pkg::wide_t'({2'b00, 1'b0, half_lon});

        near_lat = (gap > lpq_pkg::QUARTER_TURN)
                 ? lpq_pkg::angle_t'(rc_w[lpq_pkg::ANGLE_BITS-1:0])
                 : clamp_lat;
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for latlon_patch_point_query_unit: a short stimulus table, then
// random patch settings and query points, with random idle cycles on both stream sides.
// Depends on lpq_pkg and the RTL of the block; needs no files and no arguments.
module tb;
    import lpq_pkg::*;

    // Binary-angle constants for the predictor, kept wide so nothing overflows.
    localparam longint TURN_HALF    = longint'(1) << (ANGLE_BITS - 1);
    localparam longint TURN_QUARTER = longint'(1) << (ANGLE_BITS - 2);

    // Writes to any index from here up must leave the patch untouched.
    localparam int         FIRST_UNUSED_REG = int'(REG_HALF_LON) + 1;
    localparam cfg_index_t REG_UNUSED       = cfg_index_t'(200);

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int TAIL_CYCLES     = 8;
    localparam int CYCLE_LIMIT     = 400000;  // several times the slowest correct run

    // One result item as it appears on m_axis_tdata; the first member is the top bits.
    typedef struct packed {
        logic [6:0] pad;
        angle_t     near_lon;
        angle_t     near_lat;
        angle_t     corner_lon;
        angle_t     corner_lat;
        angle_t     clamp_lon;
        angle_t     clamp_lat;
        logic       inside_res;
    } patch_res_t;

    // A stimulus table row is either a register write or a query item. A typed row
    // carries its own expected inside flag; all of its output angles are expected zero.
    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        cfg_index_t idx;
        cfg_data_t  val;
        angle_t     lat;
        angle_t     lon;
        bit         typed;
        bit         want_inside;
    } step_t;

    localparam int NSTEPS = 39;
    localparam step_t SCRIPT [NSTEPS] = '{
        // Patch after reset: a single point at zero, so every output angle is zero.
        '{ROW_ITEM, '0, '0, 24'sd0,      24'sd0,      1'b1, 1'b1},
        '{ROW_ITEM, '0, '0, 24'sd1,      24'sd0,      1'b1, 1'b0},
        '{ROW_ITEM, '0, '0, 24'sd0,      -24'sd1,     1'b1, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h7FFFFF,  24'h800000,  1'b1, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h800000,  24'h7FFFFF,  1'b1, 1'b0},
        // Longitude half a turn away: latitude is reflected but still clamps to zero.
        '{ROW_ITEM, '0, '0, 24'sd0,      24'h800000,  1'b1, 1'b0},
        // A small patch away from the origin.
        '{ROW_CFG, REG_CENTER_LAT, 24'd1000,    '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_CENTER_LON, -24'sd2000,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LAT,   24'd500,     '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LON,   24'd800,     '0, '0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'sd1000,   -24'sd2000,  1'b0, 1'b0},  // zero direction
        '{ROW_ITEM, '0, '0, 24'sd1500,   -24'sd1200,  1'b0, 1'b0},  // north-east edge
        '{ROW_ITEM, '0, '0, 24'sd1501,   -24'sd1199,  1'b0, 1'b0},  // just outside
        '{ROW_ITEM, '0, '0, 24'sd500,    -24'sd2800,  1'b0, 1'b0},  // south-west edge
        '{ROW_ITEM, '0, '0, -24'sd8387608, 24'sd8386608, 1'b0, 1'b0},  // exact half turn
        '{ROW_ITEM, '0, '0, 24'sd0,      24'sd5998000, 1'b0, 1'b0},  // gap past a quarter
        '{ROW_ITEM, '0, '0, 24'h7FFFFF,  24'h7FFFFF,  1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h800000,  24'h800000,  1'b0, 1'b0},
        // Center at the top of both ranges, widest latitude, zero longitude width.
        '{ROW_CFG, REG_CENTER_LAT, 24'h400000,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_CENTER_LON, 24'h7FFFFF,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LAT,   24'h7FFFFF,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LON,   24'h000000,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_UNUSED,     24'hFFFFFF,  '0, '0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h400000,  24'h7FFFFF,  1'b0, 1'b0},
        // Wrapped longitude difference is one, the plain one almost a full turn.
        '{ROW_ITEM, '0, '0, 24'h800000,  24'h800000,  1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'sd0,      24'hBFFFFF,  1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h7FFFFF,  24'sd0,      1'b0, 1'b0},
        // Center at the bottom of both ranges, zero latitude width, widest longitude.
        '{ROW_CFG, REG_CENTER_LAT, 24'hC00000,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_CENTER_LON, 24'h800000,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LAT,   24'h000000,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LON,   24'h7FFFFF,  '0, '0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'hC00000,  24'h800000,  1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h400000,  24'h7FFFFF,  1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'sd0,      24'sd0,      1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h800000,  24'h400000,  1'b0, 1'b0},
        // Center latitude beyond its stated range is used as written.
        '{ROW_CFG, REG_CENTER_LAT, 24'h7FFFFF,  '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, REG_HALF_LAT,   24'h7FFFFF,  '0, '0, 1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h800000,  24'sd100,    1'b0, 1'b0},
        '{ROW_ITEM, '0, '0, 24'h7FFFFF,  -24'sd1,     1'b0, 1'b0}
    };

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    cfg_index_t cfg_index     = '0;
    cfg_data_t  cfg_wdata     = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    // [23:0] point_lat, [47:24] point_lon
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] inside_res, [24:1] clamp_lat, [48:25] clamp_lon, [72:49] corner_lat,
    // [96:73] corner_lon, [120:97] near_lat, [144:121] near_lon, [151:145] zero
    logic [151:0] m_axis_tdata;

    // The predictor's own copy of the patch registers, updated on every write.
    angle_t cen_lat = '0;
    angle_t cen_lon = '0;
    half_t  hsz_lat = '0;
    half_t  hsz_lon = '0;

    patch_res_t  pending_results [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int unsigned cycle_count  = 0;
    bit          steady       = 1'b0;  // when set, neither side idles

    latlon_patch_point_query_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Maps any value onto one turn, [-half turn, half turn).
    function automatic longint wrap_turn(longint x);
        angle_t t;
        t = x[ANGLE_BITS-1:0];
        return longint'(t);
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        longint r;
        r = x;
        if (r < lo) begin
            r = lo;
        end
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // Expected result item for one query point against the current patch.
    function automatic patch_res_t patch_query(angle_t plat, angle_t plon);
        longint pa, po, ca, co, ha, ho, dlat, dlon, nlat, nlon, refl;
        patch_res_t r;
        pa   = plat;
        po   = plon;
        ca   = cen_lat;
        co   = cen_lon;
        ha   = longint'(hsz_lat);
        ho   = longint'(hsz_lon);
        dlat = wrap_turn(pa - ca);
        dlon = wrap_turn(po - co);
        nlat = ca + dlat;
        nlon = co + dlon;
        r    = '0;
        // The inside test deliberately uses the plain, unwrapped differences.
        r.inside_res = (mag(ca - pa) <= ha) && (mag(co - po) <= ho);
        r.clamp_lat  = angle_t'(clip(nlat, ca - ha, ca + ha));
        r.clamp_lon  = angle_t'(clip(nlon, co - ho, co + ho));
        // A wrapped difference of zero picks the south or west side.
        r.corner_lat = angle_t'((dlat > 0) ? ca + ha : ca - ha);
        r.corner_lon = angle_t'((dlon > 0) ? co + ho : co - ho);
        r.near_lon   = r.clamp_lon;
        // Beyond a quarter turn past the longitude edge, the shortest path goes over
        // the pole, so the latitude is reflected through a half turn.
        if (mag(wrap_turn(co - nlon)) - ho > TURN_QUARTER) begin
            refl       = TURN_HALF - nlat;
            r.near_lat = angle_t'(clip(ca + wrap_turn(refl - ca), ca - ha, ca + ha));
        end else begin
            r.near_lat = r.clamp_lat;
        end
        return r;
    endfunction

    // Random register value, weighted toward the ends of each range.
    function automatic cfg_data_t pick_reg(cfg_index_t idx);
        cfg_data_t v;
        case (idx)
            REG_CENTER_LAT: begin
                case ($urandom_range(4))
                    0: v = 24'h400000;
                    1: v = 24'hC00000;
                    2: v = cfg_data_t'($urandom);  // may lie outside the stated range
                    default: v = cfg_data_t'($urandom_range(8388608) - 4194304);
                endcase
            end
            REG_CENTER_LON: begin
                case ($urandom_range(3))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    default: v = cfg_data_t'($urandom);
                endcase
            end
            default: begin
                // Half sizes. Small ones matter most: they let the pole reflection happen.
                case ($urandom_range(5))
                    0: v = 24'h000000;
                    1: v = 24'h7FFFFF;
                    2, 3: v = cfg_data_t'($urandom_range(2000));
                    4: v = cfg_data_t'($urandom_range(4194304));
                    default: v = cfg_data_t'($urandom);  // top bit must be dropped
                endcase
            end
        endcase
        return v;
    endfunction

    // Random coordinate on one axis: anywhere, near the box, on its edges, half a turn
    // from the center, or at the ends of the field.
    function automatic angle_t pick_coord(angle_t c, half_t h);
        longint base, span;
        angle_t v;
        base = c;
        span = longint'(h);
        case ($urandom_range(9))
            0, 1, 2: v = angle_t'($urandom);
            3, 4, 5: v = angle_t'(base - span + longint'($urandom_range(32'(2 * span))));
            6, 7: v = angle_t'(base + ($urandom_range(1) ? span : -span)
                               + longint'($urandom_range(2)) - 1);
            8: v = angle_t'(base + TURN_HALF + longint'($urandom_range(4)) - 2);
            default: v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb: mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_angle(string name, angle_t got_v, angle_t want_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
        end
    endtask

    // Lowers valid and waits until every expected result has come back; the block is
    // idle afterwards, so the patch registers may be rewritten.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One register write. The enable is lowered in its own cycle so that back-to-back
    // writes never assign it twice in one time step.
    task automatic write_reg(cfg_index_t idx, cfg_data_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CENTER_LAT: cen_lat = angle_t'(val);
            REG_CENTER_LON: cen_lon = angle_t'(val);
            REG_HALF_LAT:   hsz_lat = half_t'(val);
            REG_HALF_LON:   hsz_lon = half_t'(val);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Offers one query item, with random idle cycles ahead of it, and records its
    // expected result at the edge where it is taken.
    task automatic send_point(angle_t lat, angle_t lon, patch_res_t want);
        while (!steady && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lon, lat};
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(want);
    endtask

    // Result side: random back-pressure, and every accepted item is compared field by
    // field with the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        patch_res_t got, want;
        m_axis_tready <= steady || ($urandom_range(99) >= 26);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = patch_res_t'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("result item with no query waiting");
            end else begin
                want = pending_results.pop_front();
                if (got.inside_res !== want.inside_res) begin
                    report_mismatch($sformatf("inside_res is %b, expected %b",
                                              got.inside_res, want.inside_res));
                end
                check_angle("clamp_lat", got.clamp_lat, want.clamp_lat);
                check_angle("clamp_lon", got.clamp_lon, want.clamp_lon);
                check_angle("corner_lat", got.corner_lat, want.corner_lat);
                check_angle("corner_lon", got.corner_lon, want.corner_lon);
                check_angle("near_lat", got.near_lat, want.near_lat);
                check_angle("near_lon", got.near_lon, want.near_lon);
                if (got.pad !== want.pad) begin
                    report_mismatch($sformatf("padding bits are %b", got.pad));
                end
            end
            results_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        step_t     st;
        patch_res_t want;
        angle_t    plat, plon;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Typed rows are checked against the value in the table, the
        // rest against the predictor.
        for (int i = 0; i < NSTEPS; i++) begin
            st = SCRIPT[i];
            if (st.kind == ROW_CFG) begin
                drain();
                write_reg(st.idx, st.val);
            end else begin
                if (st.typed) begin
                    want            = '0;
                    want.inside_res = st.want_inside;
                end else begin
                    want = patch_query(st.lat, st.lon);
                end
                send_point(st.lat, st.lon, want);
            end
        end

        // Random part: a fresh patch in every phase. Each phase starts with a full
        // drain, so the sender pauses until every expected result has come. One phase
        // runs with no idle cycles on either side.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            steady = (ph == 2);
            write_reg(REG_CENTER_LAT, pick_reg(REG_CENTER_LAT));
            write_reg(REG_CENTER_LON, pick_reg(REG_CENTER_LON));
            write_reg(REG_HALF_LAT, pick_reg(REG_HALF_LAT));
            write_reg(REG_HALF_LON, pick_reg(REG_HALF_LON));
            if ($urandom_range(1)) begin
                write_reg(cfg_index_t'($urandom_range(255, FIRST_UNUSED_REG)),
                          cfg_data_t'($urandom));
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                plat = pick_coord(cen_lat, hsz_lat);
                plon = pick_coord(cen_lon, hsz_lon);
                send_point(plat, plon, patch_query(plat, plon));
            end
        end
        steady = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
